FILE: design/hpts_pkg.sv
// Shared constants, types and helpers for the head pose tracker smoother.
`default_nettype none

package hpts_pkg;

  // Default coordinate width of the incoming face boxes.
  localparam int COORD_BITS_DEF = 12;

  // Fixed field widths.
  localparam int CMD_W      = 2;
  localparam int FRAME_W    = 13;
  localparam int GAIN_W     = 16;
  localparam int LIMIT_W    = 8;
  localparam int COUNT_W    = 8;
  localparam int POSE_W     = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int OUT_DATA_W = 64;
  localparam int OUT_USER_W = 1;

  // Divider geometry: the divisor is twice the frame size, and a quotient below 2^15 is
  // produced bit by bit; anything larger saturates.
  localparam int DEN_W     = FRAME_W + 1;
  localparam int QUOT_BITS = 15;
  localparam int SUM_W     = POSE_W + 3;

  // Command codes on the input side.
  localparam logic [CMD_W-1:0] CMD_BOX   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_FRAME = 2'd1;
  localparam logic [CMD_W-1:0] CMD_TICK  = 2'd2;

  // Result kinds.
  localparam logic KIND_REPORT = 1'b0;
  localparam logic KIND_TICK   = 1'b1;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PAN_GAIN     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SMOOTH       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STALE_LIMIT  = 3'd4;

  // Register reset values.
  localparam logic [FRAME_W-1:0] FRAME_WIDTH_RST  = 13'd640;
  localparam logic [FRAME_W-1:0] FRAME_HEIGHT_RST = 13'd480;
  localparam logic [GAIN_W-1:0]  PAN_GAIN_RST     = 16'd256;
  localparam logic [GAIN_W-1:0]  SMOOTH_RST       = 16'd13107;
  localparam logic [LIMIT_W-1:0] STALE_LIMIT_RST  = 8'd30;

  // Gain applied to the nearness channel so that it shares the x/y datapath:
  // 256 * 128 gives the 32768 scale of Q1.15.
  localparam logic [GAIN_W-1:0] Z_GAIN = 16'd256;

  // Result of the shared divider, handed back to the sequencer.
  typedef struct packed {
    logic              done;
    logic [POSE_W-1:0] quot;
  } div_res_t;

  // Saturate a widened signed value to the Q1.15 range.
  function automatic logic [POSE_W-1:0] sat_pose(input logic signed [SUM_W-1:0] v);
    logic [POSE_W-1:0] r;
    if (v > SUM_W'(signed'(32767))) begin
      r = 16'h7FFF;
    end else if (v < -SUM_W'(signed'(32768))) begin
      r = 16'h8000;
    end else begin
      r = v[POSE_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: design/hpts_div.sv
// Iterative restoring divider with a saturating quotient, one quotient bit per cycle.
`default_nettype none

module hpts_div #(
  parameter int NUM_W = 42
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire logic [NUM_W-1:0]           num,
  input  wire logic [hpts_pkg::DEN_W-1:0] den,
  output hpts_pkg::div_res_t              res
);
  import hpts_pkg::*;

  localparam int CNT_W = $clog2(QUOT_BITS + 1);

  logic                 busy;
  logic                 done;
  logic                 ovf;
  logic [CNT_W-1:0]     cnt;
  logic [DEN_W-1:0]     rem;
  logic [QUOT_BITS-1:0] low;
  logic [QUOT_BITS-1:0] quot;
  logic [DEN_W:0]       rem_sh;
  logic [DEN_W:0]       rem_sub;
  logic                 qbit;

  always_comb begin
    rem_sh  = {rem, low[QUOT_BITS-1]};
    qbit    = (rem_sh >= {1'b0, den});
    rem_sub = rem_sh - {1'b0, den};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else if (start) begin
      // A quotient of 2^15 or more saturates; otherwise the upper part already sits
      // below the divisor and only the low bits remain to be brought down.
      if (num[NUM_W-1:QUOT_BITS] >= (NUM_W - QUOT_BITS)'(den)) begin
        ovf  <= 1'b1;
        done <= 1'b1;
        busy <= 1'b0;
      end else begin
        ovf  <= 1'b0;
        done <= 1'b0;
        rem  <= num[QUOT_BITS+DEN_W-1:QUOT_BITS];
        low  <= num[QUOT_BITS-1:0];
        cnt  <= CNT_W'(QUOT_BITS);
        busy <= 1'b1;
      end
    end else if (busy) begin
      rem  <= qbit ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
      quot <= {quot[QUOT_BITS-2:0], qbit};
      low  <= {low[QUOT_BITS-2:0], 1'b0};
      cnt  <= cnt - CNT_W'(1);
      busy <= (cnt != CNT_W'(1));
      done <= (cnt == CNT_W'(1));
    end else begin
      done <= 1'b0;
    end
  end

  assign res.done = done;
  assign res.quot = ovf ? {1'b1, {QUOT_BITS{1'b0}}} : {1'b0, quot};

endmodule

`default_nettype wire

FILE: design/head_pose_tracker_smoother.sv
// Top level of the head pose tracker smoother: sequencer, shared multiplier and state.
`default_nettype none

// The block sits between a face detector and a display loop. Words on the slave side
// carry a command in s_tuser: a face box, an end of detection frame, or a display tick.
// Box words only update the running largest-area box and the face count; they give no
// result. An end-of-frame word turns the kept box of a non-empty frame into clamped
// Q1.15 head offsets and returns a detection report; a tick word advances the stale
// counter and the three low-pass filters and returns the smoothed pose. Unused command
// three is dropped. Configuration is written through cfg_we, cfg_index and cfg_data;
// the user must write it only while the block is idle, as the block does not enforce
// it. Each write takes effect at the clock edge where cfg_we is high. One
// signed-by-unsigned multiplier is shared by the area, offset and filter steps, and
// one restoring divider (one quotient bit per cycle) serves the three offsets in turn.
// Box words pass the area and box steps, ticks a stale step and three multiply-add
// passes, frame ends three rounds of multiply, divider start and wait; a saturating
// offset skips the division; an empty frame goes to the final step. s_tready is high
// only while the sequencer is idle. Results wait in an output register: if the receiver
// stalls, the next word is still accepted and worked on, and the sequencer holds before
// its final step until the earlier result has been taken. Synchronous reset restores
// the register defaults, clears all tracking state and drops any pending result.

module head_pose_tracker_smoother #(
  parameter int COORD_BITS = hpts_pkg::COORD_BITS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  // Input words.
  input  wire logic                             s_tvalid,
  output logic                                  s_tready,
  // s_tdata from bit 0: box_x, box_y, box_w, box_h (COORD_BITS each), zero fill.
  input  wire logic [((4*COORD_BITS+7)/8)*8-1:0] s_tdata,
  // s_tuser: cmd.
  input  wire logic [hpts_pkg::CMD_W-1:0]       s_tuser,
  // Result words.
  output logic                                  m_tvalid,
  input  wire logic                             m_tready,
  // m_tdata from bit 0: face_count (8), pose_x (16), pose_y (16), pose_z (16),
  // pose_valid (1), connected (1), zero fill.
  output logic [hpts_pkg::OUT_DATA_W-1:0]       m_tdata,
  // m_tuser: kind.
  output logic [hpts_pkg::OUT_USER_W-1:0]       m_tuser,
  // Configuration writes.
  input  wire logic                             cfg_we,
  input  wire logic [hpts_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [hpts_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import hpts_pkg::*;

  localparam int CB      = COORD_BITS;
  // Multiplier operand wide enough for the frame offsets and the 17-bit filter error.
  localparam int MA_W    = (CB + 4 > 17) ? CB + 4 : 17;
  localparam int PW      = MA_W + GAIN_W;
  localparam int NUM_W   = PW + 9;
  localparam int AREA_W  = 2 * CB;
  localparam int TQ_W    = POSE_W + 1;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_AREA   = 4'd1;
  localparam logic [3:0] S_BOX    = 4'd2;
  localparam logic [3:0] S_FMUL   = 4'd3;
  localparam logic [3:0] S_FSTART = 4'd4;
  localparam logic [3:0] S_FWAIT  = 4'd5;
  localparam logic [3:0] S_STALE  = 4'd6;
  localparam logic [3:0] S_TMUL   = 4'd7;
  localparam logic [3:0] S_TADD   = 4'd8;
  localparam logic [3:0] S_DONE   = 4'd9;

  // Configuration registers.
  logic [FRAME_W-1:0] frame_width;
  logic [FRAME_W-1:0] frame_height;
  logic [GAIN_W-1:0]  pan_gain;
  logic [GAIN_W-1:0]  smooth_factor;
  logic [LIMIT_W-1:0] stale_limit;

  // Tracking state.
  logic [AREA_W-1:0]        best_area;
  logic [CB-1:0]            best_x, best_y, best_w, best_h;
  logic [COUNT_W-1:0]       frame_faces;
  logic signed [POSE_W-1:0] raw_pose [3];
  logic                     raw_valid;
  logic [LIMIT_W-1:0]       stale_count;
  logic signed [POSE_W-1:0] smooth_pose [3];

  // Sequencer and captured word.
  logic [3:0]         state;
  logic [1:0]         ch;
  logic [CB-1:0]      in_x, in_y, in_w, in_h;
  logic               res_kind;
  logic [COUNT_W-1:0] res_count;

  // Output register.
  logic               out_valid;
  logic               out_kind;
  logic [COUNT_W-1:0] out_count;
  logic [POSE_W-1:0]  out_x, out_y, out_z;
  logic               out_pvalid;
  logic               out_conn;

  // Shared datapath.
  logic signed [MA_W-1:0]  mul_a;
  logic [GAIN_W-1:0]       mul_b;
  logic signed [PW:0]      prod_full;
  logic signed [PW-1:0]    prod;
  logic [PW-1:0]           prod_mag;
  logic [FRAME_W-1:0]      w_eff, h_eff;
  logic [MA_W-1:0]         dx, dy, dz;
  logic [NUM_W-1:0]        div_num;
  logic [DEN_W-1:0]        div_den;
  logic                    div_start;
  div_res_t                div_res;
  logic signed [SUM_W-1:0] frame_val;
  logic [POSE_W-1:0]       frame_pose;
  logic signed [POSE_W-1:0] tgt, cur;
  logic [PW:0]             tick_sum;
  logic [TQ_W-1:0]         tick_q;
  logic signed [SUM_W-1:0] tick_val;
  logic [POSE_W-1:0]       tick_pose;
  logic                    conn;
  logic [AREA_W-1:0]       area;

  assign conn  = (stale_count < stale_limit);
  assign w_eff = (frame_width == '0) ? FRAME_W'(1) : frame_width;
  assign h_eff = (frame_height == '0) ? FRAME_W'(1) : frame_height;

  // Offsets from the kept box; all fit the operand width, so wrap-around arithmetic
  // leaves the correct two's complement value.
  assign dx = MA_W'(w_eff) - (MA_W'(best_x) << 1) - MA_W'(best_w);
  assign dy = MA_W'(h_eff) - (MA_W'(best_y) << 1) - MA_W'(best_h);
  assign dz = (MA_W'(best_w) << 2) + MA_W'(best_w) - MA_W'(w_eff);

  // Filter operands for the channel in hand: the target is zero once disconnected,
  // the raw pose while detection is fresh, and the filter itself while briefly lost.
  assign cur = smooth_pose[ch];
  assign tgt = !conn ? '0 : (raw_valid ? raw_pose[ch] : smooth_pose[ch]);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_AREA: begin
        mul_a = $signed(MA_W'(in_w));
        mul_b = GAIN_W'(in_h);
      end
      S_FMUL: begin
        case (ch)
          2'd0: begin
            mul_a = $signed(dx);
            mul_b = pan_gain;
          end
          2'd1: begin
            mul_a = $signed(dy);
            mul_b = pan_gain;
          end
          default: begin
            mul_a = $signed(dz);
            mul_b = Z_GAIN;
          end
        endcase
      end
      S_TMUL: begin
        mul_a = MA_W'(tgt) - MA_W'(cur);
        mul_b = smooth_factor;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_full = mul_a * $signed({1'b0, mul_b});
  assign prod_mag  = prod[PW-1] ? PW'(-prod) : PW'(prod);
  assign area      = prod[AREA_W-1:0];

  // Rounded division: (2*|d*g*128| + W) / (2*W), so the numerator is |d*g| shifted by
  // eight and the divisor is twice the frame size.
  assign div_num   = {1'b0, prod_mag, 8'd0} + NUM_W'(ch == 2'd1 ? h_eff : w_eff);
  assign div_den   = (ch == 2'd1) ? {h_eff, 1'b0} : {w_eff, 1'b0};
  assign div_start = (state == S_FSTART);

  hpts_div #(
    .NUM_W (NUM_W)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .res   (div_res)
  );

  assign frame_val  = prod[PW-1] ? -SUM_W'(div_res.quot) : SUM_W'(div_res.quot);
  assign frame_pose = sat_pose(frame_val);

  // Filter step: error times factor, rounded at bit 16 with ties away from zero.
  assign tick_sum  = {1'b0, prod_mag} + ((PW + 1)'(1) << 15);
  assign tick_q    = tick_sum[16 +: TQ_W];
  assign tick_val  = SUM_W'(cur) + (prod[PW-1] ? -SUM_W'(tick_q) : SUM_W'(tick_q));
  assign tick_pose = sat_pose(tick_val);

  assign s_tready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width   <= FRAME_WIDTH_RST;
      frame_height  <= FRAME_HEIGHT_RST;
      pan_gain      <= PAN_GAIN_RST;
      smooth_factor <= SMOOTH_RST;
      stale_limit   <= STALE_LIMIT_RST;
      best_area     <= '0;
      best_x        <= '0;
      best_y        <= '0;
      best_w        <= '0;
      best_h        <= '0;
      frame_faces   <= '0;
      raw_pose      <= '{default: '0};
      raw_valid     <= 1'b0;
      stale_count   <= '0;
      smooth_pose   <= '{default: '0};
      state         <= S_IDLE;
      ch            <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_FRAME_WIDTH:  frame_width   <= cfg_data[FRAME_W-1:0];
          REG_FRAME_HEIGHT: frame_height  <= cfg_data[FRAME_W-1:0];
          REG_PAN_GAIN:     pan_gain      <= cfg_data;
          REG_SMOOTH:       smooth_factor <= cfg_data;
          REG_STALE_LIMIT:  stale_limit   <= cfg_data[LIMIT_W-1:0];
          default: ;
        endcase
      end

      // The final step reloads the output register itself when it hands over a word.
      if (out_valid && m_tready && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            in_x <= s_tdata[0*CB +: CB];
            in_y <= s_tdata[1*CB +: CB];
            in_w <= s_tdata[2*CB +: CB];
            in_h <= s_tdata[3*CB +: CB];
            unique case (s_tuser)
              CMD_BOX: begin
                state <= S_AREA;
              end
              CMD_FRAME: begin
                res_kind  <= KIND_REPORT;
                res_count <= frame_faces;
                ch        <= '0;
                if (frame_faces == '0) begin
                  // Empty frame: the raw pose is kept but no longer valid.
                  raw_valid <= 1'b0;
                  best_area <= '0;
                  best_x    <= '0;
                  best_y    <= '0;
                  best_w    <= '0;
                  best_h    <= '0;
                  state     <= S_DONE;
                end else begin
                  state <= S_FMUL;
                end
              end
              CMD_TICK: begin
                state <= S_STALE;
              end
              default: begin
                state <= S_IDLE;
              end
            endcase
          end
        end
        S_AREA: begin
          prod  <= prod_full[PW-1:0];
          state <= S_BOX;
        end
        S_BOX: begin
          if (frame_faces != '1) begin
            frame_faces <= frame_faces + COUNT_W'(1);
          end
          // Strictly larger wins, so the first of equal boxes is kept.
          if (area > best_area) begin
            best_area <= area;
            best_x    <= in_x;
            best_y    <= in_y;
            best_w    <= in_w;
            best_h    <= in_h;
          end
          state <= S_IDLE;
        end
        S_FMUL: begin
          prod  <= prod_full[PW-1:0];
          state <= S_FSTART;
        end
        S_FSTART: begin
          state <= S_FWAIT;
        end
        S_FWAIT: begin
          if (div_res.done) begin
            raw_pose[ch] <= frame_pose;
            if (ch == 2'd2) begin
              raw_valid   <= 1'b1;
              best_area   <= '0;
              best_x      <= '0;
              best_y      <= '0;
              best_w      <= '0;
              best_h      <= '0;
              frame_faces <= '0;
              state       <= S_DONE;
            end else begin
              ch    <= ch + 2'd1;
              state <= S_FMUL;
            end
          end
        end
        S_STALE: begin
          if (raw_valid) begin
            stale_count <= '0;
          end else if (stale_count < stale_limit) begin
            stale_count <= stale_count + LIMIT_W'(1);
          end
          res_kind  <= KIND_TICK;
          res_count <= '0;
          ch        <= '0;
          state     <= S_TMUL;
        end
        S_TMUL: begin
          prod  <= prod_full[PW-1:0];
          state <= S_TADD;
        end
        S_TADD: begin
          smooth_pose[ch] <= tick_pose;
          if (ch == 2'd2) begin
            state <= S_DONE;
          end else begin
            ch    <= ch + 2'd1;
            state <= S_TMUL;
          end
        end
        S_DONE: begin
          if (!out_valid || m_tready) begin
            out_valid  <= 1'b1;
            out_kind   <= res_kind;
            out_count  <= res_count;
            out_pvalid <= raw_valid;
            out_conn   <= conn;
            if (res_kind == KIND_TICK) begin
              out_x <= smooth_pose[0];
              out_y <= smooth_pose[1];
              out_z <= smooth_pose[2];
            end else if (raw_valid) begin
              out_x <= raw_pose[0];
              out_y <= raw_pose[1];
              out_z <= raw_pose[2];
            end else begin
              out_x <= '0;
              out_y <= '0;
              out_z <= '0;
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_kind;
  assign m_tdata  = {6'd0, out_conn, out_pvalid, out_z, out_y, out_x, out_count};

`ifndef SYNTHESIS
  // The divider only answers while the sequencer waits for it.
  a_div_done_waited: assert property (@(posedge clk) disable iff (rst)
    div_res.done |-> (state == S_FWAIT))
    else $error("divider result outside the wait step");

  // Every accepted box, frame or tick word takes the sequencer out of the idle step;
  // the spare command is dropped in the idle step.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready &&
     (s_tuser == CMD_BOX || s_tuser == CMD_FRAME || s_tuser == CMD_TICK)) |=> !s_tready)
    else $error("input accepted on two consecutive cycles");

  // A report without a valid pose carries zero offsets.
  a_empty_report_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_kind == KIND_REPORT) && !out_pvalid) |->
      (out_x == '0 && out_y == '0 && out_z == '0))
    else $error("invalid report with nonzero pose");

  // Tick results never carry a face count.
  a_tick_no_count: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_kind == KIND_TICK)) |-> (out_count == '0))
    else $error("tick result with nonzero face count");
`endif

endmodule

`default_nettype wire

FILE: dv/tb.sv
// Self-checking testbench for the head pose tracker smoother.
`timescale 1ns / 1ps

// The bench drives face boxes, end-of-frame words and display ticks into the slave
// stream and checks every result word against its own model of the block. That model
// tracks the largest-area box of each frame, the raw pose, the stale counter and the
// three low-pass filters. Expected words are worked out when an input word is accepted
// and are queued. Each result word is then checked, field by field, against the oldest
// entry in the queue.
// The test tasks run in turn from one initial block. A directed pass covers the field
// extremes and the corner cases. After it come phases at extreme register settings, a
// frame whose face count saturates, a long receiver hold-off, and random tracking
// sequences under random settings. Registers are only rewritten once the block has gone
// quiet.

module tb;
  import hpts_pkg::*;

  // The slave side has no name for the spare command code, which the block drops.
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int COORD_MAX    = 4095;
  // Cycles allowed after the last expected word for a box word still in flight, and
  // for the block to settle before a register write or the end of the run.
  localparam int SETTLE_CYCLES = 100;

  typedef struct {
    logic                     kind;
    logic [COUNT_W-1:0]       count;
    logic signed [POSE_W-1:0] x;
    logic signed [POSE_W-1:0] y;
    logic signed [POSE_W-1:0] z;
    logic                     valid;
    logic                     conn;
  } pose_word_t;

  // Every input of the block starts at a known value.
  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [4*12-1:0]        s_tdata = '0;
  logic [CMD_W-1:0]       s_tuser = CMD_BOX;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_DATA_W-1:0]  m_tdata;
  logic [OUT_USER_W-1:0]  m_tuser;
  logic                   cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  head_pose_tracker_smoother dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #5 clk = ~clk;

  // Our copy of the register file, starting from the reset values.
  logic [FRAME_W-1:0] frame_w_reg  = FRAME_WIDTH_RST;
  logic [FRAME_W-1:0] frame_h_reg  = FRAME_HEIGHT_RST;
  logic [GAIN_W-1:0]  gain_reg     = PAN_GAIN_RST;
  logic [GAIN_W-1:0]  alpha_reg    = SMOOTH_RST;
  logic [LIMIT_W-1:0] stale_lim_reg = STALE_LIMIT_RST;

  // Our copy of the tracking state; reset clears all of it.
  logic [23:0]              best_area = '0;
  logic [11:0]              best_x = '0, best_y = '0, best_w = '0, best_h = '0;
  logic [COUNT_W-1:0]       faces_in_frame = '0;
  logic signed [POSE_W-1:0] raw_pose [3] = '{default: '0};
  logic                     raw_ok = 1'b0;
  logic [LIMIT_W-1:0]       missed_ticks = '0;
  logic signed [POSE_W-1:0] filt_pose [3] = '{default: '0};

  pose_word_t expected_poses [$];
  pose_word_t oldest_pose;
  int         errors = 0;
  int         sent_items = 0;

  // Sender and receiver pacing.
  int  burst_left = 0;
  bit  steady_sender = 1'b0;
  int  hold_request = 0;
  int  hold_left = 0;
  int  rdy_phase_left = 0;
  int  rdy_style = 0;
  logic [7:0] rdy_pattern = 8'hFF;

  // Division rounded to nearest, ties away from zero.
  function automatic longint div_nearest(input longint num, input longint den);
    longint mag, q;
    mag = (num < 0) ? -num : num;
    q = (2 * mag + den) / (2 * den);
    return (num < 0) ? -q : q;
  endfunction

  function automatic logic signed [POSE_W-1:0] clamp_q15(input longint v);
    if (v > 32767) return 16'sh7FFF;
    if (v < -32768) return 16'sh8000;
    return v[POSE_W-1:0];
  endfunction

  // Advances the tracking state by one accepted word and queues the word it should
  // produce, if any.
  task automatic track_word(input logic [CMD_W-1:0] cmd, input logic [11:0] bx,
                            input logic [11:0] by, input logic [11:0] bw,
                            input logic [11:0] bh);
    pose_word_t res;
    longint     area, w, h, dx, dy, dz, t, s;
    res = '{kind: KIND_REPORT, count: '0, x: '0, y: '0, z: '0, valid: 1'b0, conn: 1'b0};
    case (cmd)
      CMD_BOX: begin
        area = longint'(bw) * longint'(bh);
        if (faces_in_frame != 8'd255) faces_in_frame = faces_in_frame + 8'd1;
        if (area > longint'(best_area)) begin
          best_area = area[23:0];
          best_x = bx;
          best_y = by;
          best_w = bw;
          best_h = bh;
        end
      end
      CMD_FRAME: begin
        // A zero frame size is taken as one.
        w = (frame_w_reg == 0) ? 1 : longint'(frame_w_reg);
        h = (frame_h_reg == 0) ? 1 : longint'(frame_h_reg);
        res.count = faces_in_frame;
        if (faces_in_frame == 0) begin
          // Empty frame: the raw pose is kept but no longer counts as fresh.
          raw_ok = 1'b0;
        end else begin
          dx = w - 2 * longint'(best_x) - longint'(best_w);
          dy = h - 2 * longint'(best_y) - longint'(best_h);
          dz = 5 * longint'(best_w) - w;
          raw_pose[0] = clamp_q15(div_nearest(dx * longint'(gain_reg) * 128, w));
          raw_pose[1] = clamp_q15(div_nearest(dy * longint'(gain_reg) * 128, h));
          raw_pose[2] = clamp_q15(div_nearest(dz * 32768, w));
          raw_ok = 1'b1;
          res.x = raw_pose[0];
          res.y = raw_pose[1];
          res.z = raw_pose[2];
        end
        best_area = '0;
        best_x = '0;
        best_y = '0;
        best_w = '0;
        best_h = '0;
        faces_in_frame = '0;
        res.valid = raw_ok;
        res.conn = (missed_ticks < stale_lim_reg);
        expected_poses.push_back(res);
      end
      CMD_TICK: begin
        if (raw_ok) missed_ticks = '0;
        else if (missed_ticks < stale_lim_reg) missed_ticks = missed_ticks + LIMIT_W'(1);
        res.conn = (missed_ticks < stale_lim_reg);
        for (int k = 0; k < 3; k++) begin
          s = longint'(filt_pose[k]);
          // Disconnected filters decay to zero; a stale face holds its place.
          if (!res.conn) t = 0;
          else if (raw_ok) t = longint'(raw_pose[k]);
          else t = s;
          filt_pose[k] = clamp_q15(s + div_nearest((t - s) * longint'(alpha_reg), 65536));
        end
        res.kind = KIND_TICK;
        res.x = filt_pose[0];
        res.y = filt_pose[1];
        res.z = filt_pose[2];
        res.valid = raw_ok;
        expected_poses.push_back(res);
      end
      default: begin
      end
    endcase
  endtask

  // Offers one word on the slave side and waits for it to be taken. Words go out in
  // bursts of random length; between bursts a sender that is not steady may drop tvalid.
  task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [11:0] bx,
                           input logic [11:0] by, input logic [11:0] bw,
                           input logic [11:0] bh);
    int gap;
    @(negedge clk);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = steady_sender ? 0 : $urandom_range(0, 6);
      if (gap != 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {bh, bw, by, bx};
    do @(posedge clk); while (!s_tready);
    if (cmd != CMD_UNUSED) sent_items++;
    track_word(cmd, bx, by, bw, bh);
  endtask

  // Frame-end, tick and spare words carry random payload bits, which the block ignores.
  task automatic send_ctl(input logic [CMD_W-1:0] cmd);
    send_word(cmd, 12'($urandom), 12'($urandom), 12'($urandom), 12'($urandom));
  endtask

  // A box either anywhere in the coordinate range or plausibly inside the frame.
  task automatic send_box(input bit wild);
    int lim_w, lim_h, bw, bh;
    if (wild) begin
      send_word(CMD_BOX, 12'($urandom), 12'($urandom), 12'($urandom), 12'($urandom));
    end else begin
      lim_w = (frame_w_reg > COORD_MAX) ? COORD_MAX : int'(frame_w_reg);
      lim_h = (frame_h_reg > COORD_MAX) ? COORD_MAX : int'(frame_h_reg);
      bw = $urandom_range(0, lim_w);
      bh = $urandom_range(0, lim_h);
      send_word(CMD_BOX, 12'($urandom_range(0, lim_w - bw)),
                12'($urandom_range(0, lim_h - bh)), 12'(bw), 12'(bh));
    end
  endtask

  // Drops tvalid, waits for every expected word and lets any box word still in the
  // sequencer finish.
  task automatic settle_block;
    @(negedge clk);
    s_tvalid <= 1'b0;
    burst_left = 0;
    while (expected_poses.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_FRAME_WIDTH:  frame_w_reg = val[FRAME_W-1:0];
      REG_FRAME_HEIGHT: frame_h_reg = val[FRAME_W-1:0];
      REG_PAN_GAIN:     gain_reg = val;
      REG_SMOOTH:       alpha_reg = val;
      REG_STALE_LIMIT:  stale_lim_reg = val[LIMIT_W-1:0];
      default: begin
      end
    endcase
  endtask

  task automatic set_tracking_regs(input int fw, input int fh, input int gain,
                                   input int alpha, input int lim);
    settle_block();
    write_reg(REG_FRAME_WIDTH, 16'(fw));
    write_reg(REG_FRAME_HEIGHT, 16'(fh));
    write_reg(REG_PAN_GAIN, 16'(gain));
    write_reg(REG_SMOOTH, 16'(alpha));
    write_reg(REG_STALE_LIMIT, 16'(lim));
  endtask

  // Mostly well-formed frames with ticks between them; some frames are empty so that
  // the stale counter can run out, and a share of the words are noise.
  task automatic run_tracking(input int n_items);
    int stop_at, pick, n;
    stop_at = sent_items + n_items;
    while (sent_items < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        repeat ($urandom_range(0, 5)) send_box(1'b0);
        send_ctl(CMD_FRAME);
        repeat ($urandom_range(1, 3)) send_ctl(CMD_TICK);
      end else if (pick < 70) begin
        n = int'(stale_lim_reg) + 3;
        if (n > 40) n = 40;
        send_ctl(CMD_FRAME);
        repeat ($urandom_range(1, n)) send_ctl(CMD_TICK);
      end else if (pick < 85) begin
        repeat ($urandom_range(1, 4)) send_box(1'b1);
        send_ctl(CMD_FRAME);
        send_ctl(CMD_TICK);
      end else begin
        repeat ($urandom_range(1, 4)) begin
          send_word(CMD_W'($urandom_range(0, 3)), 12'($urandom), 12'($urandom),
                    12'($urandom), 12'($urandom));
        end
      end
    end
  endtask

  // Corner cases at the reset settings.
  task automatic test_directed_cases;
    // A tick before any detection, then a frame with no faces.
    send_ctl(CMD_TICK);
    send_ctl(CMD_FRAME);
    send_ctl(CMD_UNUSED);
    // A frame whose only box has zero area still gives a valid pose.
    send_word(CMD_BOX, 12'd0, 12'd0, 12'd0, 12'd0);
    send_ctl(CMD_FRAME);
    send_ctl(CMD_TICK);
    // A box at the top of the coordinate range drives every offset into saturation.
    send_word(CMD_BOX, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF);
    send_ctl(CMD_FRAME);
    send_ctl(CMD_TICK);
    // Equal areas: the first box seen is kept. A zero box leads, a spare word sits between.
    send_word(CMD_BOX, 12'd0, 12'd0, 12'd0, 12'hFFF);
    send_word(CMD_BOX, 12'd100, 12'd50, 12'd40, 12'd30);
    send_ctl(CMD_UNUSED);
    send_word(CMD_BOX, 12'd300, 12'd200, 12'd30, 12'd40);
    send_word(CMD_BOX, 12'd10, 12'd10, 12'd20, 12'd20);
    send_ctl(CMD_FRAME);
    send_ctl(CMD_TICK);
    send_ctl(CMD_TICK);
    // A face in the middle of the frame, then a lost face held by the filters.
    send_word(CMD_BOX, 12'd288, 12'd208, 12'd64, 12'd64);
    send_ctl(CMD_FRAME);
    send_ctl(CMD_TICK);
    send_ctl(CMD_FRAME);
    send_ctl(CMD_TICK);
    send_ctl(CMD_TICK);
  endtask

  // Phases at the extremes of every register, with zero frame sizes and a zero stale
  // limit among them.
  task automatic test_register_extremes;
    set_tracking_regs(0, 0, 65535, 65535, 0);
    run_tracking(80);
    set_tracking_regs(4096, 4096, 0, 0, 1);
    run_tracking(80);
    set_tracking_regs(1, 1, 1, 1, 255);
    run_tracking(80);
    set_tracking_regs(8191, 8191, 32768, 32768, 2);
    run_tracking(80);
    set_tracking_regs(int'(FRAME_WIDTH_RST), int'(FRAME_HEIGHT_RST), int'(PAN_GAIN_RST),
                      int'(SMOOTH_RST), int'(STALE_LIMIT_RST));
    run_tracking(80);
  endtask

  // More than 255 faces in one frame: the count in the report stops at 255.
  task automatic test_face_count_saturation;
    repeat ($urandom_range(256, 270)) send_box(1'b0);
    send_ctl(CMD_FRAME);
    send_ctl(CMD_TICK);
  endtask

  // The receiver holds off for a long stretch while the sender keeps offering words
  // without gaps, so the output register fills and the block stalls its input.
  task automatic test_output_backpressure;
    settle_block();
    steady_sender = 1'b1;
    hold_request = 400;
    repeat (8) begin
      repeat ($urandom_range(1, 3)) send_box(1'b0);
      send_ctl(CMD_FRAME);
      send_ctl(CMD_TICK);
      send_ctl(CMD_TICK);
    end
    steady_sender = 1'b0;
  endtask

  // Random register settings, each followed by a stretch of random tracking. The first
  // phase runs with a sender that never pauses.
  task automatic test_random_tracking;
    int fw, fh, gain, lim;
    for (int p = 0; p < 6; p++) begin
      fw = ($urandom_range(0, 9) < 7) ? $urandom_range(16, 1920) : $urandom_range(1, 4096);
      fh = ($urandom_range(0, 9) < 7) ? $urandom_range(16, 1080) : $urandom_range(1, 4096);
      gain = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 1024) : $urandom_range(0, 65535);
      lim = ($urandom_range(0, 9) < 6) ? $urandom_range(1, 8) : $urandom_range(0, 255);
      set_tracking_regs(fw, fh, gain, $urandom_range(0, 65535), lim);
      steady_sender = (p == 0);
      run_tracking(80);
    end
    steady_sender = 1'b0;
  endtask

  // Receiver: a long hold-off when one is asked for, otherwise a stall style that
  // is picked anew for each phase of random length (always ready, coin flip, mostly
  // stalled, or a rotating eight-bit pattern).
  always @(negedge clk) begin
    if (hold_request != 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      if (rdy_phase_left == 0) begin
        rdy_style = $urandom_range(0, 3);
        rdy_phase_left = $urandom_range(20, 200);
        rdy_pattern = 8'($urandom) | 8'h01;
      end
      rdy_phase_left--;
      case (rdy_style)
        0: m_tready <= 1'b1;
        1: m_tready <= 1'($urandom_range(0, 1));
        2: m_tready <= ($urandom_range(0, 3) == 0);
        default: begin
          m_tready <= rdy_pattern[0];
          rdy_pattern = {rdy_pattern[0], rdy_pattern[7:1]};
        end
      endcase
    end
  end

  function automatic void check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endfunction

  // Result checker: every word taken from the master side is compared with the oldest
  // expectation.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (expected_poses.size() == 0) begin
        $display("%0t: unexpected result word, expected none, actual kind %0d data %h",
                 $time, m_tuser[0], m_tdata);
        errors++;
      end else begin
        oldest_pose = expected_poses.pop_front();
        check_field("kind", oldest_pose.kind, m_tuser[0]);
        check_field("face_count", oldest_pose.count, m_tdata[7:0]);
        check_field("pose_x", oldest_pose.x, $signed(m_tdata[23:8]));
        check_field("pose_y", oldest_pose.y, $signed(m_tdata[39:24]));
        check_field("pose_z", oldest_pose.z, $signed(m_tdata[55:40]));
        check_field("pose_valid", oldest_pose.valid, m_tdata[56]);
        check_field("connected", oldest_pose.conn, m_tdata[57]);
      end
    end
  end

  initial begin
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    test_directed_cases();
    test_register_extremes();
    test_face_count_saturation();
    test_output_backpressure();
    test_random_tracking();
    settle_block();
    if (errors == 0) begin
      $display("PASS head_pose_tracker_smoother");
    end else begin
      $display("FAIL head_pose_tracker_smoother");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("FAIL head_pose_tracker_smoother");
    $finish;
  end

endmodule

FILE: sim.f
design/hpts_pkg.sv
design/hpts_div.sv
design/head_pose_tracker_smoother.sv
dv/tb.sv
